FILE: design/lps_pkg.sv
package lps_pkg;

   // Raster size
   localparam int COL_BITS   = 7;
   localparam int ROW_BITS   = 6;
   localparam int DELTA_BITS = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
   localparam int ACC_BITS   = DELTA_BITS + 1;

   // Command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // Per-axis step direction codes
   localparam logic [1:0] STEP_NONE = 2'd0;
   localparam logic [1:0] STEP_INC  = 2'd1;
   localparam logic [1:0] STEP_DEC  = 2'd3;

   typedef struct packed {
      logic                command;
      logic [COL_BITS-1:0] start_x;
      logic [ROW_BITS-1:0] start_y;
      logic [COL_BITS-1:0] end_x;
      logic [ROW_BITS-1:0] end_y;
      logic                colour;
   } req_type;

   typedef struct packed {
      logic [COL_BITS-1:0] pixel_x;
      logic [ROW_BITS-1:0] pixel_y;
      logic                pixel_black;
      logic                last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [COL_BITS-1:0]   cur_x;
      logic [ROW_BITS-1:0]   cur_y;
      logic [ACC_BITS-1:0]   error_acc;
      logic [DELTA_BITS-1:0] major_delta;
      logic [DELTA_BITS-1:0] minor_delta;
      logic [1:0]            x_step_sign;
      logic [1:0]            y_step_sign;
      logic                  x_is_major;
      logic [ACC_BITS-1:0]   pixels_left;
      logic                  black_latch;
      logic                  line_active;
   } line_state_type;

endpackage

FILE: design/lps_advance.sv
// Next-state and pixel logic for one accepted transaction.
module lps_advance (
   input  lps_pkg::line_state_type state_ff,
   input  lps_pkg::req_type        req,
   output lps_pkg::line_state_type state_in,
   output lps_pkg::rsp_type        rsp,
   output logic                    emit
);

   function automatic logic [lps_pkg::COL_BITS-1:0] step_col(
      input logic [lps_pkg::COL_BITS-1:0] pos,
      input logic [1:0]                   sign
   );
      logic [lps_pkg::COL_BITS-1:0] res;
      case (sign)
         lps_pkg::STEP_INC: res = pos + lps_pkg::COL_BITS'(1);
         lps_pkg::STEP_DEC: res = pos - lps_pkg::COL_BITS'(1);
         default:           res = pos;
      endcase
      return res;
   endfunction

   function automatic logic [lps_pkg::ROW_BITS-1:0] step_row(
      input logic [lps_pkg::ROW_BITS-1:0] pos,
      input logic [1:0]                   sign
   );
      logic [lps_pkg::ROW_BITS-1:0] res;
      case (sign)
         lps_pkg::STEP_INC: res = pos + lps_pkg::ROW_BITS'(1);
         lps_pkg::STEP_DEC: res = pos - lps_pkg::ROW_BITS'(1);
         default:           res = pos;
      endcase
      return res;
   endfunction

   logic [lps_pkg::COL_BITS-1:0]   adx;
   logic [lps_pkg::ROW_BITS-1:0]   ady;
   logic [lps_pkg::DELTA_BITS-1:0] adx_ext;
   logic [lps_pkg::DELTA_BITS-1:0] ady_ext;
   logic [1:0]                     x_sign;
   logic [1:0]                     y_sign;
   logic [lps_pkg::ACC_BITS-1:0]   err_sum;
   logic                           minor_move;
   logic [lps_pkg::ACC_BITS-1:0]   left_dec;

   // Load: endpoint deltas and directions
   always_comb begin
      if (req.end_x > req.start_x) begin
         adx    = req.end_x - req.start_x;
         x_sign = lps_pkg::STEP_INC;
      end else if (req.end_x < req.start_x) begin
         adx    = req.start_x - req.end_x;
         x_sign = lps_pkg::STEP_DEC;
      end else begin
         adx    = '0;
         x_sign = lps_pkg::STEP_NONE;
      end
      if (req.end_y > req.start_y) begin
         ady    = req.end_y - req.start_y;
         y_sign = lps_pkg::STEP_INC;
      end else if (req.end_y < req.start_y) begin
         ady    = req.start_y - req.end_y;
         y_sign = lps_pkg::STEP_DEC;
      end else begin
         ady    = '0;
         y_sign = lps_pkg::STEP_NONE;
      end
   end

   assign adx_ext = lps_pkg::DELTA_BITS'(adx);
   assign ady_ext = lps_pkg::DELTA_BITS'(ady);

   // Step: error accumulator stays below twice the major delta
   assign err_sum    = state_ff.error_acc + lps_pkg::ACC_BITS'(state_ff.minor_delta);
   assign minor_move = (err_sum >= lps_pkg::ACC_BITS'(state_ff.major_delta));
   assign left_dec   = state_ff.pixels_left - lps_pkg::ACC_BITS'(1);

   // Pixel out of the current position
   assign rsp.pixel_x     = state_ff.cur_x;
   assign rsp.pixel_y     = state_ff.cur_y;
   assign rsp.pixel_black = state_ff.black_latch;
   assign rsp.last_pixel  = (state_ff.pixels_left == lps_pkg::ACC_BITS'(1));
   assign emit = (req.command == lps_pkg::CMD_STEP) && state_ff.line_active;

   // Next state
   always_comb begin
      state_in = state_ff;
      if (req.command == lps_pkg::CMD_LOAD) begin
         state_in.cur_x       = req.start_x;
         state_in.cur_y       = req.start_y;
         state_in.error_acc   = '0;
         state_in.x_step_sign = x_sign;
         state_in.y_step_sign = y_sign;
         state_in.x_is_major  = (adx_ext > ady_ext);
         if (adx_ext > ady_ext) begin
            state_in.major_delta = adx_ext;
            state_in.minor_delta = ady_ext;
            state_in.pixels_left = lps_pkg::ACC_BITS'(adx_ext) + lps_pkg::ACC_BITS'(1);
         end else begin
            state_in.major_delta = ady_ext;
            state_in.minor_delta = adx_ext;
            state_in.pixels_left = lps_pkg::ACC_BITS'(ady_ext) + lps_pkg::ACC_BITS'(1);
         end
         state_in.black_latch = req.colour;
         state_in.line_active = 1'b1;
      end else if (state_ff.line_active) begin
         if (minor_move) begin
            state_in.error_acc = err_sum - lps_pkg::ACC_BITS'(state_ff.major_delta);
         end else begin
            state_in.error_acc = err_sum;
         end
         if (state_ff.x_is_major) begin
            state_in.cur_x = step_col(state_ff.cur_x, state_ff.x_step_sign);
            if (minor_move) begin
               state_in.cur_y = step_row(state_ff.cur_y, state_ff.y_step_sign);
            end
         end else begin
            state_in.cur_y = step_row(state_ff.cur_y, state_ff.y_step_sign);
            if (minor_move) begin
               state_in.cur_x = step_col(state_ff.cur_x, state_ff.x_step_sign);
            end
         end
         state_in.pixels_left = left_dec;
         state_in.line_active = (left_dec != '0);
      end
   end

endmodule

FILE: design/line_pixel_stepper_top.sv
// Line rasterizer: a load transaction (command 0) latches two endpoints and a
// colour and returns nothing; each step transaction (command 1) then returns
// one pixel, walking from the first endpoint to the second, with the final
// pixel flagged by last_pixel. Step transactions with no line loaded, or after
// the last pixel, return nothing. A load at any time restarts. Each accepted
// transaction's pixel is loaded into the response register in the cycle
// after acceptance; one transaction per clock is sustained as long as
// the response side keeps taking pixels, the response register being the
// only stage.
module line_pixel_stepper_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lps_pkg::rsp_type rsp_data
);

   lps_pkg::line_state_type state_ff;
   lps_pkg::line_state_type state_in;
   lps_pkg::rsp_type        rsp_data_ff;
   lps_pkg::rsp_type        rsp_data_in;
   logic                    rsp_valid_ff;
   logic                    emit;
   logic                    accept;

   lps_advance u_advance (
      .state_ff (state_ff),
      .req      (req_data),
      .state_in (state_in),
      .rsp      (rsp_data_in),
      .emit     (emit)
   );

   // Take a transaction whenever the response register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Line state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/sv/tb_line_pixel_stepper_top.sv
module tb_line_pixel_stepper_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lps_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int WORK_TARGET = 850;

   // Line walker: tracks the rasterizer state and holds the pixels still owed
   class pixel_tracker;
      rsp_type                pending_pixels[$];
      int                     mismatches;
      logic [COL_BITS-1:0]    pos_x;
      logic [ROW_BITS-1:0]    pos_y;
      logic [ACC_BITS-1:0]    err_acc;
      logic [DELTA_BITS-1:0]  major_d;
      logic [DELTA_BITS-1:0]  minor_d;
      logic [1:0]             dir_x;
      logic [1:0]             dir_y;
      logic                   x_major;
      logic [ACC_BITS-1:0]    remaining;
      logic                   colour_latch;
      logic                   active;

      function new();
         mismatches   = 0;
         pos_x        = '0;
         pos_y        = '0;
         err_acc      = '0;
         major_d      = '0;
         minor_d      = '0;
         dir_x        = STEP_NONE;
         dir_y        = STEP_NONE;
         x_major      = 1'b0;
         remaining    = '0;
         colour_latch = 1'b0;
         active       = 1'b0;
      endfunction

      task report(string msg);
         $display("mismatch @%0t: %s", $time, msg);
         mismatches++;
      endtask

      // Returns 1 when the transaction does real work (a load, or a step on a live line)
      function bit note_request(req_type r);
         logic [DELTA_BITS-1:0] adx;
         logic [DELTA_BITS-1:0] ady;
         rsp_type               px;
         if (r.command == CMD_LOAD) begin
            if (r.end_x > r.start_x) begin
               adx   = DELTA_BITS'(r.end_x - r.start_x);
               dir_x = STEP_INC;
            end else if (r.end_x < r.start_x) begin
               adx   = DELTA_BITS'(r.start_x - r.end_x);
               dir_x = STEP_DEC;
            end else begin
               adx   = '0;
               dir_x = STEP_NONE;
            end
            if (r.end_y > r.start_y) begin
               ady   = DELTA_BITS'(r.end_y - r.start_y);
               dir_y = STEP_INC;
            end else if (r.end_y < r.start_y) begin
               ady   = DELTA_BITS'(r.start_y - r.end_y);
               dir_y = STEP_DEC;
            end else begin
               ady   = '0;
               dir_y = STEP_NONE;
            end
            pos_x   = r.start_x;
            pos_y   = r.start_y;
            err_acc = '0;
            // ties step along y
            x_major = (adx > ady);
            major_d = x_major ? adx : ady;
            minor_d = x_major ? ady : adx;
            remaining    = ACC_BITS'(major_d) + 1'b1;
            colour_latch = r.colour;
            active       = 1'b1;
            return 1'b1;
         end
         if (!active)
            return 1'b0;

         px.pixel_x     = pos_x;
         px.pixel_y     = pos_y;
         px.pixel_black = colour_latch;
         px.last_pixel  = (remaining == 1);
         pending_pixels.push_back(px);

         // major axis always moves; minor axis moves when the error catches up
         err_acc = err_acc + ACC_BITS'(minor_d);
         if (x_major) begin
            pos_x = pos_x + ((dir_x == STEP_DEC) ? {COL_BITS{1'b1}} :
                             COL_BITS'(dir_x == STEP_INC));
            if (err_acc >= ACC_BITS'(major_d)) begin
               pos_y   = pos_y + ((dir_y == STEP_DEC) ? {ROW_BITS{1'b1}} :
                                  ROW_BITS'(dir_y == STEP_INC));
               err_acc = err_acc - ACC_BITS'(major_d);
            end
         end else begin
            pos_y = pos_y + ((dir_y == STEP_DEC) ? {ROW_BITS{1'b1}} :
                             ROW_BITS'(dir_y == STEP_INC));
            if (err_acc >= ACC_BITS'(major_d)) begin
               pos_x   = pos_x + ((dir_x == STEP_DEC) ? {COL_BITS{1'b1}} :
                                  COL_BITS'(dir_x == STEP_INC));
               err_acc = err_acc - ACC_BITS'(major_d);
            end
         end
         remaining = remaining - 1'b1;
         if (remaining == 0)
            active = 1'b0;
         return 1'b1;
      endfunction

      task check_pixel(rsp_type got);
         rsp_type want;
         if (pending_pixels.size() == 0) begin
            report($sformatf("pixel (%0d,%0d) with nothing outstanding",
                             got.pixel_x, got.pixel_y));
            return;
         end
         want = pending_pixels.pop_front();
         if (got.pixel_x !== want.pixel_x)
            report($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
         if (got.pixel_y !== want.pixel_y)
            report($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
         if (got.pixel_black !== want.pixel_black)
            report($sformatf("pixel_black got %b want %b",
                             got.pixel_black, want.pixel_black));
         if (got.last_pixel !== want.last_pixel)
            report($sformatf("last_pixel got %b want %b",
                             got.last_pixel, want.last_pixel));
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   pixel_tracker tracker = new();
   int  work_items = 0;
   bit  req_steady = 1'b0;
   bit  rsp_steady = 1'b0;

   line_pixel_stepper_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic req_type make_req(logic cmd, int sx, int sy, int ex, int ey,
                                        logic col);
      req_type r;
      r.command = cmd;
      r.start_x = COL_BITS'(sx);
      r.start_y = ROW_BITS'(sy);
      r.end_x   = COL_BITS'(ex);
      r.end_y   = ROW_BITS'(ey);
      r.colour  = col;
      return r;
   endfunction

   // Send one transaction; valid stays up across back-to-back transfers
   task automatic send_req(req_type r);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if (tracker.note_request(r))
         work_items++;
   endtask

   // Step transactions carry random don't-care endpoint fields
   task automatic send_steps(int n);
      repeat (n)
         send_req(make_req(CMD_STEP, $urandom_range(0, 127), $urandom_range(0, 63),
                           $urandom_range(0, 127), $urandom_range(0, 63),
                           1'($urandom_range(0, 1))));
   endtask

   // Hold off the sender until every outstanding pixel has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_pixels.size() != 0);
   endtask

   // Response side: random stalls, checks each accepted pixel
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = rsp_steady ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_pixel(rsp_data);
         if ($urandom_range(0, 49) == 0)
            rsp_steady = !rsp_steady;
      end
   end

   // Watchdog: too long without any transfer on either channel
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle = 0;
         else
            idle++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Main stimulus
   initial begin
      int  pick, shape, style, sx, sy, ex, ey, d, ax, ay, k;
      bit  up_x, up_y;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: step with nothing loaded
      send_steps(1);
      // single point, then a step past the end
      send_req(make_req(CMD_LOAD, 5, 5, 5, 5, 1'b1));
      send_steps(2);
      // full-raster corners; the second load cuts the first line short
      send_req(make_req(CMD_LOAD, 0, 0, 127, 63, 1'b1));
      send_steps(2);
      send_req(make_req(CMD_LOAD, 127, 63, 0, 0, 1'b0));
      send_steps(2);
      // y major, x up, y down
      send_req(make_req(CMD_LOAD, 10, 20, 12, 17, 1'b1));
      send_steps(4);
      // x major, x down, y up
      send_req(make_req(CMD_LOAD, 20, 10, 17, 12, 1'b0));
      send_steps(4);
      // diagonal tie steps along y
      send_req(make_req(CMD_LOAD, 30, 30, 32, 32, 1'b1));
      send_steps(3);
      drain();

      // Random: mostly complete lines, some cut short, some noise
      while (work_items < WORK_TARGET) begin
         pick       = $urandom_range(0, 99);
         req_steady = ($urandom_range(0, 4) == 0);
         if (pick < 4)
            drain();
         if (pick < 85) begin
            shape = $urandom_range(0, 9);
            sx = $urandom_range(0, 127);
            sy = $urandom_range(0, 63);
            if (shape < 5) begin
               ex = $urandom_range((sx > 8) ? sx - 8 : 0, (sx < 119) ? sx + 8 : 127);
               ey = $urandom_range((sy > 8) ? sy - 8 : 0, (sy < 55) ? sy + 8 : 63);
            end else if (shape < 7) begin
               ex = $urandom_range(0, 127);
               ey = $urandom_range(0, 63);
            end else if (shape == 7) begin
               ex = $urandom_range(0, 127);
               ey = $urandom_range(0, 63);
               if ($urandom_range(0, 1))
                  ey = sy;
               else
                  ex = sx;
            end else if (shape == 8) begin
               up_x = 1'($urandom_range(0, 1));
               up_y = 1'($urandom_range(0, 1));
               ax = up_x ? 127 - sx : sx;
               ay = up_y ? 63 - sy : sy;
               d  = $urandom_range(0, (ax < ay) ? ax : ay);
               ex = up_x ? sx + d : sx - d;
               ey = up_y ? sy + d : sy - d;
            end else begin
               ex = sx;
               ey = sy;
            end
            send_req(make_req(CMD_LOAD, sx, sy, ex, ey, 1'($urandom_range(0, 1))));
            style = $urandom_range(0, 9);
            if (style == 0) begin
               k = $urandom_range(0, int'(tracker.remaining) - 1);
               send_steps(k);
            end else begin
               while (tracker.active)
                  send_steps(1);
               if (style == 1)
                  send_steps($urandom_range(1, 3));
            end
         end else begin
            send_req(make_req(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                              $urandom_range(0, 63), $urandom_range(0, 127),
                              $urandom_range(0, 63), 1'($urandom_range(0, 1))));
         end
      end

      // Wrap up: let the last pixels out, then a few quiet cycles
      drain();
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
design/lps_pkg.sv
design/lps_advance.sv
design/line_pixel_stepper_top.sv
tb/sv/tb_line_pixel_stepper_top.sv
